// File: hw/rtl/assert_macros.svh
// assertion helpers for the port checker fbe_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// concurrent assertion on the block clock and reset
`define ASSERT_DEF(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// File: hw/rtl/fbe_pkg.sv
// ----------------------------------------------------------------------------
// fbe_pkg
// Types, constants and helpers of the transmit frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package fbe_pkg;

  // input word kinds
  localparam logic KindStart = 1'b0;
  localparam logic KindData  = 1'b1;

  // frame layout
  localparam int unsigned MinFrameBytesDef = 14;
  localparam int unsigned QueueDepthDef    = 2;
  localparam logic [7:0]  HeaderBytes      = 8'd4;
  localparam logic [7:0]  OffMarker        = 8'd0;
  localparam logic [7:0]  OffHdr1          = 8'd1;
  localparam logic [7:0]  OffHdr2          = 8'd2;
  localparam logic [7:0]  OffChecksum      = 8'd3;
  localparam logic [7:0]  StartMarkerRst   = 8'd126;

  // escaping rule
  localparam logic [3:0] EscType      = 4'd5;
  localparam logic [7:0] EscPrevA     = 8'd129;
  localparam logic [7:0] EscPrevB     = 8'd136;
  localparam logic [7:0] EscZeroIn    = 8'd0;
  localparam logic [7:0] EscZeroOut   = 8'd255;
  localparam logic [7:0] EscFlagIn    = 8'd168;
  localparam logic [7:0] EscFlagOut   = 8'd254;
  localparam logic [7:0] NibbleMask   = 8'h0F;

  // one queued job: an optional data word followed by an optional tail
  typedef struct packed {
    logic       has_data;
    logic       has_tail;
    logic [7:0] offset;
    logic [7:0] value;
    logic       replaced;
    logic [6:0] count;
    logic [7:0] total;
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [7:0] csum;
  } entry_t;

  function automatic logic [7:0] nib_sum(input logic [7:0] b);
    nib_sum = ((b >> 4) & NibbleMask) + (b & NibbleMask);
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fbe_front.sv
// ----------------------------------------------------------------------------
// fbe_front
// Accepts start and data words, escapes data, keeps frame state, queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic            kind_i,
  input  wire logic [6:0]      frame_length_i,
  input  wire logic [4:0]      sequence_req_i,
  input  wire logic [3:0]      frame_type_i,
  input  wire logic            escape_enable_i,
  input  wire logic [7:0]      data_byte_i,
  output logic                 push_o,
  output fbe_pkg::entry_t      entry_o
);

  logic       active_q, active_d;
  logic [6:0] length_q, length_d;
  logic [7:0] hdr1_q, hdr1_d;
  logic [7:0] hdr2_q, hdr2_d;
  logic       esc_q, esc_d;
  logic [6:0] seen_q, seen_d;
  logic [7:0] prev_q, prev_d;
  logic [7:0] sum_q, sum_d;
  logic [6:0] reps_q, reps_d;

  logic [7:0] hdr1_n, hdr2_n, bval;
  logic       rep, last;

  always_comb begin
    hdr1_n = {frame_length_i, sequence_req_i[4]};
    hdr2_n = {sequence_req_i[3:0], frame_type_i};

    // escape check against the previous emitted byte
    bval = data_byte_i;
    rep  = 1'b0;
    if (esc_q && (seen_q != 7'd0)) begin
      if (((prev_q == fbe_pkg::EscPrevA) || (prev_q == fbe_pkg::EscPrevB)) &&
          (data_byte_i == fbe_pkg::EscZeroIn)) begin
        bval = fbe_pkg::EscZeroOut;
        rep  = 1'b1;
      end else if ((prev_q == fbe_pkg::EscPrevB) && (data_byte_i == fbe_pkg::EscFlagIn)) begin
        bval = fbe_pkg::EscFlagOut;
        rep  = 1'b1;
      end
    end

    active_d = active_q;
    length_d = length_q;
    hdr1_d   = hdr1_q;
    hdr2_d   = hdr2_q;
    esc_d    = esc_q;
    seen_d   = seen_q;
    prev_d   = prev_q;
    sum_d    = sum_q;
    reps_d   = reps_q;
    push_o   = 1'b0;
    last     = 1'b0;

    entry_o          = '0;
    entry_o.hdr1     = hdr1_q;
    entry_o.hdr2     = hdr2_q;
    entry_o.total    = {1'b0, length_q} + fbe_pkg::HeaderBytes;

    if (accept_i && (kind_i == fbe_pkg::KindStart)) begin
      length_d = frame_length_i;
      hdr1_d   = hdr1_n;
      hdr2_d   = hdr2_n;
      esc_d    = escape_enable_i && (frame_type_i == fbe_pkg::EscType);
      seen_d   = '0;
      prev_d   = '0;
      reps_d   = '0;
      sum_d    = fbe_pkg::nib_sum(hdr1_n) + fbe_pkg::nib_sum(hdr2_n);
      active_d = (frame_length_i != 7'd0);
      // empty frame: the tail goes out at once
      push_o         = (frame_length_i == 7'd0);
      entry_o.has_tail = 1'b1;
      entry_o.hdr1   = hdr1_n;
      entry_o.hdr2   = hdr2_n;
      entry_o.total  = fbe_pkg::HeaderBytes;
      entry_o.csum   = sum_d;
      entry_o.count  = '0;
    end else if (accept_i && active_q) begin
      reps_d   = reps_q + {6'd0, rep};
      sum_d    = sum_q + fbe_pkg::nib_sum(bval);
      prev_d   = bval;
      seen_d   = seen_q + 7'd1;
      last     = (seen_d == length_q);
      active_d = !last;
      push_o            = 1'b1;
      entry_o.has_data  = 1'b1;
      entry_o.has_tail  = last;
      entry_o.offset    = fbe_pkg::HeaderBytes + {1'b0, seen_q};
      entry_o.value     = bval;
      entry_o.replaced  = rep;
      entry_o.count     = reps_d;
      entry_o.csum      = sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      length_q <= '0;
      hdr1_q   <= '0;
      hdr2_q   <= '0;
      esc_q    <= 1'b0;
      seen_q   <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      reps_q   <= '0;
    end else begin
      active_q <= active_d;
      length_q <= length_d;
      hdr1_q   <= hdr1_d;
      hdr2_q   <= hdr2_d;
      esc_q    <= esc_d;
      seen_q   <= seen_d;
      prev_q   <= prev_d;
      sum_q    <= sum_d;
      reps_q   <= reps_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbe_queue.sv
// ----------------------------------------------------------------------------
// fbe_queue
// Small job queue between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_queue #(
  parameter int unsigned Depth = fbe_pkg::QueueDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  fbe_pkg::entry_t      push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 valid_o,
  output fbe_pkg::entry_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  fbe_pkg::entry_t   mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/fbe_back.sv
// ----------------------------------------------------------------------------
// fbe_back
// Plays queued jobs out as words: data, then marker, header, checksum, pad.
// ----------------------------------------------------------------------------
`default_nettype none

module fbe_back #(
  parameter int unsigned MinFrameBytes = fbe_pkg::MinFrameBytesDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [7:0]      cfg_wdata_i,
  input  wire logic            q_valid_i,
  input  fbe_pkg::entry_t      q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           offset_o,
  output logic [7:0]           value_o,
  output logic                 replaced_o,
  output logic [6:0]           replacement_count_o,
  output logic                 final_res_o
);

  localparam logic [7:0] MinBytes = 8'(MinFrameBytes);
  localparam logic [7:0] LastPad  = 8'(MinFrameBytes - 1);

  typedef enum logic [2:0] {
    PhHead, PhData, PhMark, PhHdr1, PhHdr2, PhSum, PhPad
  } phase_e;

  phase_e     ph_q, ph_d, eff;
  logic [7:0] pad_q, pad_d;
  logic [7:0] marker_q;
  logic       vld_q, vld_d;
  logic [7:0] off_q, off_d, val_q, val_d;
  logic       rep_q, rep_d, fin_q, fin_d;
  logic [6:0] cnt_q, cnt_d;
  logic       fire;

  assign fire = q_valid_i && (!vld_q || out_ready_i);

  always_comb begin
    if (ph_q == PhHead) begin
      eff = q_head_i.has_data ? PhData : PhMark;
    end else begin
      eff = ph_q;
    end

    ph_d    = ph_q;
    pad_d   = pad_q;
    vld_d   = vld_q && !out_ready_i;
    off_d   = off_q;
    val_d   = val_q;
    rep_d   = rep_q;
    fin_d   = fin_q;
    cnt_d   = cnt_q;
    q_pop_o = 1'b0;

    if (fire) begin
      vld_d = 1'b1;
      rep_d = 1'b0;
      fin_d = 1'b0;
      cnt_d = q_head_i.count;
      unique case (eff)
        PhData: begin
          off_d = q_head_i.offset;
          val_d = q_head_i.value;
          rep_d = q_head_i.replaced;
          if (q_head_i.has_tail) begin
            ph_d = PhMark;
          end else begin
            ph_d    = PhHead;
            q_pop_o = 1'b1;
          end
        end
        PhMark: begin
          off_d = fbe_pkg::OffMarker;
          val_d = marker_q;
          ph_d  = PhHdr1;
        end
        PhHdr1: begin
          off_d = fbe_pkg::OffHdr1;
          val_d = q_head_i.hdr1;
          ph_d  = PhHdr2;
        end
        PhHdr2: begin
          off_d = fbe_pkg::OffHdr2;
          val_d = q_head_i.hdr2;
          ph_d  = PhSum;
        end
        PhSum: begin
          off_d = fbe_pkg::OffChecksum;
          val_d = q_head_i.csum;
          if (q_head_i.total >= MinBytes) begin
            fin_d   = 1'b1;
            ph_d    = PhHead;
            q_pop_o = 1'b1;
          end else begin
            ph_d  = PhPad;
            pad_d = q_head_i.total;
          end
        end
        PhPad: begin
          off_d = pad_q;
          val_d = '0;
          if (pad_q == LastPad) begin
            fin_d   = 1'b1;
            ph_d    = PhHead;
            q_pop_o = 1'b1;
          end else begin
            pad_d = pad_q + 8'd1;
          end
        end
        default: begin
          ph_d = PhHead;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PhHead;
      pad_q    <= '0;
      marker_q <= fbe_pkg::StartMarkerRst;
      vld_q    <= 1'b0;
      off_q    <= '0;
      val_q    <= '0;
      rep_q    <= 1'b0;
      fin_q    <= 1'b0;
      cnt_q    <= '0;
    end else begin
      ph_q  <= ph_d;
      pad_q <= pad_d;
      if (cfg_we_i) begin
        marker_q <= cfg_wdata_i;
      end
      vld_q <= vld_d;
      off_q <= off_d;
      val_q <= val_d;
      rep_q <= rep_d;
      fin_q <= fin_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o         = vld_q;
  assign offset_o            = off_q;
  assign value_o             = val_q;
  assign replaced_o          = rep_q;
  assign replacement_count_o = cnt_q;
  assign final_res_o         = fin_q;

endmodule

`default_nettype wire

// File: hw/rtl/frame_builder_with_escape.sv
// ----------------------------------------------------------------------------
// frame_builder_with_escape
// Transmit frame builder: escapes payload bytes, then appends marker, header,
// checksum and zero padding.
// ----------------------------------------------------------------------------
// a word passes through the job queue and then the back end output register
// throughput: one data word per unstalled cycle; a frame's tail adds 4 words plus
//   padding up to MinFrameBytes, one word per unstalled cycle from the back end
// the front keeps taking input while the job queue has room
// reset (async, active low): no frame open, queue empty, marker back to 126
`default_nettype none

module frame_builder_with_escape #(
  parameter int unsigned MinFrameBytes = fbe_pkg::MinFrameBytesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration: start marker value
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  // input word channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [6:0]  frame_length_i,
  input  wire logic [4:0]  sequence_req_i,
  input  wire logic [3:0]  frame_type_i,
  input  wire logic        escape_enable_i,
  input  wire logic [7:0]  data_byte_i,
  // output word channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       offset_o,
  output logic [7:0]       value_o,
  output logic             replaced_o,
  output logic [6:0]       replacement_count_o,
  output logic             final_res_o
);

  logic            q_full, q_valid, q_pop, push, accept;
  fbe_pkg::entry_t push_entry, head_entry;

  // a word is taken whenever the queue can hold a job
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  // front: header latch, escaping, checksum, job build
  fbe_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .frame_length_i  (frame_length_i),
    .sequence_req_i  (sequence_req_i),
    .frame_type_i    (frame_type_i),
    .escape_enable_i (escape_enable_i),
    .data_byte_i     (data_byte_i),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  // job queue decouples front and back
  fbe_queue #(
    .Depth (fbe_pkg::QueueDepthDef)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head_entry)
  );

  // back: word sequencer and output register
  fbe_back #(
    .MinFrameBytes (MinFrameBytes)
  ) u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .q_valid_i           (q_valid),
    .q_head_i            (head_entry),
    .q_pop_o             (q_pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .offset_o            (offset_o),
    .value_o             (value_o),
    .replaced_o          (replaced_o),
    .replacement_count_o (replacement_count_o),
    .final_res_o         (final_res_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/fbe_checker.sv
// ----------------------------------------------------------------------------
// fbe_checker
// Port-level checks of the frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fbe_checker #(
  parameter int unsigned MinFrameBytes = fbe_pkg::MinFrameBytesDef
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [7:0] offset_o,
  input wire logic [7:0] value_o,
  input wire logic       replaced_o,
  input wire logic       final_res_o
);

  localparam logic [7:0] LastPad = 8'(MinFrameBytes - 1);

  // stalled output word holds
  `ASSERT_DEF(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o))
  // replacement bytes are only 255 or 254
  `ASSERT_DEF(a_rep_val, out_valid_o && replaced_o |-> value_o == 8'd255 || value_o == 8'd254)
  // the first data byte is never replaced
  `ASSERT_DEF(a_rep_off, out_valid_o && replaced_o |-> offset_o > 8'd4)
  // a frame ends on the checksum or on the last pad byte
  `ASSERT_DEF(a_fin_off, out_valid_o && final_res_o |-> offset_o == 8'd3 || offset_o == LastPad)

endmodule

bind frame_builder_with_escape fbe_checker #(
  .MinFrameBytes (MinFrameBytes)
) u_fbe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .offset_o    (offset_o),
  .value_o     (value_o),
  .replaced_o  (replaced_o),
  .final_res_o (final_res_o)
);

`default_nettype wire

// File: bench/frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches both word channels and the marker register of the frame builder,
// predicts every transmitted word and compares them in order.
// ----------------------------------------------------------------------------

module frame_checker #(
  parameter int unsigned MinFrameBytes = fbe_pkg::MinFrameBytesDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire logic       in_ready_i,
  input  wire logic       kind_i,
  input  wire logic [6:0] frame_length_i,
  input  wire logic [4:0] sequence_req_i,
  input  wire logic [3:0] frame_type_i,
  input  wire logic       escape_enable_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       out_valid_i,
  input  wire logic       out_ready_i,
  input  wire logic [7:0] offset_i,
  input  wire logic [7:0] value_i,
  input  wire logic       replaced_i,
  input  wire logic [6:0] replacement_count_i,
  input  wire logic       final_res_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    logic [7:0] offset;
    logic [7:0] value;
    logic       replaced;
    logic [6:0] count;
    logic       is_last;
  } tx_word_t;

  tx_word_t   tx_words[$];
  logic [7:0] marker;
  logic       frame_open;
  logic [6:0] frame_len;
  logic [4:0] frame_seq;
  logic [3:0] frame_kind;
  logic       esc_on;
  logic [6:0] data_idx;
  logic [7:0] last_byte;
  logic [7:0] csum;
  logic [6:0] rep_count;
  int         errors = 0;

  function automatic logic [7:0] nibbles(input logic [7:0] b);
    return {4'd0, b[7:4]} + {4'd0, b[3:0]};
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic push_word(input logic [7:0] off, input logic [7:0] val,
                           input logic rep, input logic is_last);
    tx_word_t w;
    w.offset   = off;
    w.value    = val;
    w.replaced = rep;
    w.count    = rep_count;
    w.is_last  = is_last;
    tx_words.push_back(w);
  endtask

  task automatic push_tail();
    logic [7:0] hdr1;
    logic [7:0] hdr2;
    logic [7:0] total;
    hdr1  = {frame_len, frame_seq[4]};
    hdr2  = {frame_seq[3:0], frame_kind};
    total = {1'b0, frame_len} + fbe_pkg::HeaderBytes;
    push_word(fbe_pkg::OffMarker, marker, 1'b0, 1'b0);
    push_word(fbe_pkg::OffHdr1, hdr1, 1'b0, 1'b0);
    push_word(fbe_pkg::OffHdr2, hdr2, 1'b0, 1'b0);
    push_word(fbe_pkg::OffChecksum, csum, 1'b0, total >= MinFrameBytes);
    for (int pos = int'(total); pos < int'(MinFrameBytes); pos++)
      push_word(8'(pos), 8'd0, 1'b0, pos == int'(MinFrameBytes) - 1);
    frame_open = 1'b0;
  endtask

  task automatic open_frame(input logic [6:0] len, input logic [4:0] seq,
                            input logic [3:0] typ, input logic esc);
    frame_len  = len;
    frame_seq  = seq;
    frame_kind = typ;
    esc_on     = esc && (typ == fbe_pkg::EscType);
    data_idx   = '0;
    last_byte  = '0;
    rep_count  = '0;
    csum       = nibbles({len, seq[4]}) + nibbles({seq[3:0], typ});
    frame_open = 1'b1;
    if (len == 0) push_tail();
  endtask

  task automatic take_byte(input logic [7:0] b_in);
    logic [7:0] b;
    logic       rep;
    b   = b_in;
    rep = 1'b0;
    if (!frame_open) return;
    // replacement looks at the previous byte as sent, never at the first
    if (esc_on && data_idx != 0) begin
      if ((last_byte == fbe_pkg::EscPrevA || last_byte == fbe_pkg::EscPrevB) &&
          b == fbe_pkg::EscZeroIn) begin
        b   = fbe_pkg::EscZeroOut;
        rep = 1'b1;
      end else if (last_byte == fbe_pkg::EscPrevB && b == fbe_pkg::EscFlagIn) begin
        b   = fbe_pkg::EscFlagOut;
        rep = 1'b1;
      end
    end
    if (rep) rep_count++;
    csum      = csum + nibbles(b);
    last_byte = b;
    push_word(fbe_pkg::HeaderBytes + {1'b0, data_idx}, b, rep, 1'b0);
    data_idx++;
    if (data_idx == frame_len) push_tail();
  endtask

  task automatic check_word();
    tx_word_t want;
    if (tx_words.size() == 0) begin
      report("unexpected word, offset", offset_i, -1);
      return;
    end
    want = tx_words.pop_front();
    if (offset_i != want.offset) report("offset", offset_i, want.offset);
    if (value_i != want.value) report("value", value_i, want.value);
    if (replaced_i != want.replaced) report("replaced", replaced_i, want.replaced);
    if (replacement_count_i != want.count)
      report("replacement_count", replacement_count_i, want.count);
    if (final_res_i != want.is_last) report("final_res", final_res_i, want.is_last);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker     = fbe_pkg::StartMarkerRst;
      frame_open = 1'b0;
      frame_len  = '0;
      frame_seq  = '0;
      frame_kind = '0;
      esc_on     = 1'b0;
      data_idx   = '0;
      last_byte  = '0;
      csum       = '0;
      rep_count  = '0;
      tx_words.delete();
    end else begin
      if (cfg_we_i) marker = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        if (kind_i == fbe_pkg::KindStart)
          open_frame(frame_length_i, sequence_req_i, frame_type_i, escape_enable_i);
        else
          take_byte(data_byte_i);
      end
      if (out_valid_i && out_ready_i) check_word();
    end
    pending_o    = tx_words.size();
    fail_count_o = errors;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start and data words into the frame builder with random gaps and
// output stalls, sweeps the start marker, and reports the checker verdict.
// ----------------------------------------------------------------------------

module testbench;

  localparam int HoldCycles   = 60;    // long output hold-off, fills the job queue
  localparam int SettleCycles = 4;     // block latency plus margin before a marker write
  localparam int QuietLimit   = 1000;  // cycles with no handshake before giving up
  localparam int PhaseItems   = 70;    // random words per marker setting

  // block inputs, all known from time zero
  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       cfg_we_i        = 1'b0;
  logic [7:0] cfg_wdata_i     = '0;
  logic       in_valid_i      = 1'b0;
  logic       kind_i          = fbe_pkg::KindStart;
  logic [6:0] frame_length_i  = '0;
  logic [4:0] sequence_req_i  = '0;
  logic [3:0] frame_type_i    = '0;
  logic       escape_enable_i = 1'b0;
  logic [7:0] data_byte_i     = '0;
  logic       out_ready_i     = 1'b0;

  // block outputs
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] offset_o;
  logic [7:0] value_o;
  logic       replaced_o;
  logic [6:0] replacement_count_o;
  logic       final_res_o;

  int fail_count;
  int words_pending;
  int items_sent = 0;
  bit idling_on  = 1'b1;  // random gaps and stalls on both sides
  bit hold_now   = 1'b0;  // asks the output side for one long hold-off

  frame_builder_with_escape dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .kind_i,
    .frame_length_i,
    .sequence_req_i,
    .frame_type_i,
    .escape_enable_i,
    .data_byte_i,
    .out_valid_o,
    .out_ready_i,
    .offset_o,
    .value_o,
    .replaced_o,
    .replacement_count_o,
    .final_res_o
  );

  frame_checker frame_check (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_i          (in_ready_o),
    .kind_i,
    .frame_length_i,
    .sequence_req_i,
    .frame_type_i,
    .escape_enable_i,
    .data_byte_i,
    .out_valid_i         (out_valid_o),
    .out_ready_i,
    .offset_i            (offset_o),
    .value_i             (value_o),
    .replaced_i          (replaced_o),
    .replacement_count_i (replacement_count_o),
    .final_res_i         (final_res_o),
    .fail_count_o        (fail_count),
    .pending_o           (words_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // bytes that tend to trigger the replacement rule
  function automatic logic [7:0] escape_prone_byte();
    case ($urandom_range(0, 5))
      0:       return fbe_pkg::EscZeroIn;
      1:       return fbe_pkg::EscPrevA;
      2:       return fbe_pkg::EscPrevB;
      3:       return fbe_pkg::EscFlagIn;
      default: return 8'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge; valid stays up when there is no gap
  task automatic send_word(input logic kind, input logic [6:0] len, input logic [4:0] seq,
                           input logic [3:0] typ, input logic esc, input logic [7:0] b);
    int gap;
    gap = idling_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= kind;
    frame_length_i  <= len;
    sequence_req_i  <= seq;
    frame_type_i    <= typ;
    escape_enable_i <= esc;
    data_byte_i     <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // fields a word does not use get random values
  task automatic send_start(input logic [6:0] len, input logic [4:0] seq,
                            input logic [3:0] typ, input logic esc);
    send_word(fbe_pkg::KindStart, len, seq, typ, esc, 8'($urandom));
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] b);
    send_word(fbe_pkg::KindData, 7'($urandom), 5'($urandom), 4'($urandom), 1'($urandom), b);
    items_sent++;
  endtask

  // data word with no frame open, dropped by the block
  task automatic send_stray();
    send_word(fbe_pkg::KindData, 7'($urandom), 5'($urandom), 4'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  // stop offering and wait until every predicted word has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_pending != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_marker(input logic [7:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly whole frames; some are cut short by the next start, some are
  // followed by a stray data word
  task automatic random_frame();
    logic [6:0] len;
    logic [3:0] typ;
    int         pick;
    int         cut;
    pick = $urandom_range(0, 99);
    if (pick < 6) len = 7'($urandom_range(13, 40));
    else          len = 7'($urandom_range(0, 12));
    typ = ($urandom_range(0, 2) == 0) ? 4'($urandom) : fbe_pkg::EscType;
    cut = int'(len);
    if (len > 1 && $urandom_range(0, 9) == 0) cut = $urandom_range(1, int'(len) - 1);
    send_start(len, 5'($urandom), typ, $urandom_range(0, 3) != 0);
    for (int i = 0; i < cut; i++) send_data(escape_prone_byte());
    if (cut == int'(len) && $urandom_range(0, 15) == 0) send_stray();
  endtask

  // output side: fresh stall per word, or the one long hold-off when asked
  initial begin : out_side
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_now) begin
        hold_now = 1'b0;
        stall    = HoldCycles;
      end else begin
        stall = idling_on ? $urandom_range(0, 3) : 0;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // watchdog on cycles with no handshake on either channel
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    int goal;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // data with no frame open is dropped
    send_stray();
    // empty frame: the start word alone yields the full padded tail
    send_start(7'd0, 5'd31, 4'd15, 1'b1);
    // escaping frame: 0 after 136, 0 after 255 kept, 0 after 129, 168 after 136
    send_start(7'd7, 5'd0, fbe_pkg::EscType, 1'b1);
    send_data(fbe_pkg::EscPrevB);
    send_data(fbe_pkg::EscZeroIn);
    send_data(fbe_pkg::EscZeroIn);
    send_data(fbe_pkg::EscPrevA);
    send_data(fbe_pkg::EscZeroIn);
    send_data(fbe_pkg::EscPrevB);
    send_data(fbe_pkg::EscFlagIn);
    // escape type with escaping disabled
    send_start(7'd2, 5'd10, fbe_pkg::EscType, 1'b0);
    send_data(fbe_pkg::EscPrevB);
    send_data(fbe_pkg::EscZeroIn);
    // escaping enabled on another type
    send_start(7'd2, 5'd17, 4'd4, 1'b1);
    send_data(fbe_pkg::EscPrevB);
    send_data(fbe_pkg::EscFlagIn);
    // longest frame abandoned after one byte by a new start
    send_start(7'd127, 5'd31, 4'd15, 1'b1);
    send_data(8'd255);
    send_start(7'd1, 5'd0, fbe_pkg::EscType, 1'b1);
    send_data(fbe_pkg::EscZeroIn);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_marker(8'd0);
        1:       write_marker(8'd255);
        2:       write_marker(8'($urandom));
        default: write_marker(fbe_pkg::StartMarkerRst);
      endcase
      idling_on = (phase != 1);
      case (phase)
        0: begin
          // one padding byte
          send_start(7'd9, 5'($urandom), fbe_pkg::EscType, 1'b1);
          repeat (9) send_data(escape_prone_byte());
        end
        1: begin
          // exactly the minimum size, no padding
          send_start(7'd10, 5'($urandom), fbe_pkg::EscType, 1'b1);
          repeat (10) send_data(escape_prone_byte());
        end
        2: begin
          // output held off while input keeps coming, so the queue fills
          hold_now = 1'b1;
          send_start(7'd40, 5'($urandom), fbe_pkg::EscType, 1'b1);
          repeat (40) send_data(escape_prone_byte());
        end
        default: begin
          send_start(7'd127, 5'($urandom), fbe_pkg::EscType, 1'b1);
          repeat (127) send_data(escape_prone_byte());
        end
      endcase
      goal = items_sent + PhaseItems;
      while (items_sent < goal) random_frame();
      drain();
    end

    if (fail_count == 0 && words_pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
